>>> rtl/cmst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counted multiset table package
// Operation and status codes shared by the table core and its datapath.
// ----------------------------------------------------------------------------
package cmst_pkg;

  localparam int unsigned CapacityDefault  = 64;
  localparam int unsigned ValueBitsDefault = 32;

  localparam int unsigned OpBits     = 4;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned DataBits   = 32;
  localparam int unsigned AmountBits = 16;
  localparam int unsigned PosBits    = 6;
  localparam int unsigned TotalBits  = 7;

  typedef enum logic [OpBits-1:0] {
    OpInsert     = 4'd0,
    OpEraseOne   = 4'd1,
    OpEraseAll   = 4'd2,
    OpCount      = 4'd3,
    OpGet        = 4'd4,
    OpReplace    = 4'd5,
    OpCountLess  = 4'd6,
    OpCountGreat = 4'd7,
    OpCountEqual = 4'd8,
    OpLeastFreq  = 4'd9,
    OpSmallest   = 4'd10,
    OpSecondSm   = 4'd11
  } op_e;

  typedef enum logic [StatusBits-1:0] {
    StDone = 2'd0,
    StMiss = 2'd1,
    StFull = 2'd2,
    StBad  = 2'd3
  } status_e;

  // Saturating add of two counts.
  function automatic logic [DataBits-1:0] sat_add(input logic [DataBits-1:0] a,
                                                  input logic [DataBits-1:0] b);
    logic [DataBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DataBits] ? {DataBits{1'b1}} : s[DataBits-1:0];
  endfunction

endpackage

>>> rtl/counted_multiset_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counted multiset table
// Ordered table of distinct values with occurrence counts, worked by a small
// sequencer that visits one entry per cycle through a registered-read memory.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  command  | in        | start_i, busy_o    | operation_i value_i new_value_i
//           |           |                    | insert_amount_i position_i
//  result   | out       | done_o (strobe)    | status_o value_out_o count_out_o
//           |           |                    | distinct_total_o occurrence_total_o
//
// With n entries held, a command scans them all, then passes through a decide
// state and a reply state. A single-entry update adds a write state, and every
// entry moved by an insert or a removal adds a read and a write state. The
// result beat follows in the cycle after the reply, when busy is already low.
// Reset clears the sequencer registers and counters; the stores are undefined
// until written. Results cannot be stalled.
module counted_multiset_table_core #(
  parameter int unsigned CAPACITY   = cmst_pkg::CapacityDefault,
  parameter int unsigned VALUE_BITS = cmst_pkg::ValueBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [cmst_pkg::OpBits-1:0]     operation_i,
  input  logic [cmst_pkg::DataBits-1:0]   value_i,
  input  logic [cmst_pkg::DataBits-1:0]   new_value_i,
  input  logic [cmst_pkg::AmountBits-1:0] insert_amount_i,
  input  logic [cmst_pkg::PosBits-1:0]    position_i,
  output logic                            done_o,
  output logic [cmst_pkg::StatusBits-1:0] status_o,
  output logic [cmst_pkg::DataBits-1:0]   value_out_o,
  output logic [cmst_pkg::DataBits-1:0]   count_out_o,
  output logic [cmst_pkg::TotalBits-1:0]  distinct_total_o,
  output logic [cmst_pkg::DataBits-1:0]   occurrence_total_o
);

  localparam int unsigned IdxBits = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned NBits   = $clog2(CAPACITY + 1);
  localparam int unsigned DB      = cmst_pkg::DataBits;
  localparam int unsigned VB      = (VALUE_BITS < DB) ? VALUE_BITS : DB;
  localparam int unsigned CmpBits = (NBits > cmst_pkg::PosBits) ? NBits : cmst_pkg::PosBits;
  localparam int unsigned SumBits = DB + NBits;

  typedef enum logic [2:0] {
    SIdle, SScan, SDecide, SWrEntry, SRead, SWrite, SReply
  } state_e;

  // Entry memory: value and count side by side.
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];
  logic [DB-1:0]         cnt_mem [CAPACITY];
  logic [VALUE_BITS-1:0] rd_val_q;
  logic [DB-1:0]         rd_cnt_q;
  logic                  we;
  logic [IdxBits-1:0]    rd_addr, wr_addr;
  logic [VALUE_BITS-1:0] wr_val;
  logic [DB-1:0]         wr_cnt;

  state_e                          state_q;
  logic [NBits-1:0]                n_q;
  logic [SumBits-1:0]              sum_q;
  logic [cmst_pkg::OpBits-1:0]     op_q;
  logic [VALUE_BITS-1:0]           v_q, nv_q;
  logic [cmst_pkg::AmountBits-1:0] amt_q;
  logic [cmst_pkg::PosBits-1:0]    pos_q;
  logic [NBits-1:0]                i_q;      // entry being read
  logic [NBits-1:0]                j_q;      // entry whose data returns
  logic                            vld_q;    // read data in flight
  logic                            hit_q, hit2_q, uniq_q;
  logic [IdxBits-1:0]              k_q, k2_q;
  logic [DB-1:0]                   kc_q, k2c_q;
  logic [VALUE_BITS-1:0]           gv_q, lf_v_q, lo_v_q, nx_v_q;
  logic [DB-1:0]                   gc_q, lf_c_q, lo_c_q, nx_c_q, acc_q;
  logic [IdxBits-1:0]              wa_q;
  logic [VALUE_BITS-1:0]           wv_q;
  logic [DB-1:0]                   wc_q;
  logic                            shift_up_q, pend_dn_q, grow_q, shrink_q;
  logic [cmst_pkg::StatusBits-1:0] st_q;
  logic [DB-1:0]                   cnt_q, vo_q;
  logic                            done_q;

  logic [DB-1:0]      ins_sum, merge_sum;
  logic [SumBits-1:0] sum_add, sum_sub, sum_next;
  logic               full, cnt_hit;

  always_ff @(posedge clk_i) begin
    if (we) begin
      val_mem[wr_addr] <= wr_val;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    rd_val_q <= val_mem[rd_addr];
    rd_cnt_q <= cnt_mem[rd_addr];
  end

  assign rd_addr = i_q[IdxBits-1:0];

  always_comb begin
    we      = 1'b0;
    wr_addr = wa_q;
    wr_val  = wv_q;
    wr_cnt  = wc_q;
    if (state_q == SWrite) begin
      we      = 1'b1;
      wr_addr = shift_up_q ? IdxBits'(i_q + 1'b1) : IdxBits'(i_q - 1'b1);
      wr_val  = rd_val_q;
      wr_cnt  = rd_cnt_q;
    end else if (state_q == SWrEntry) begin
      we = 1'b1;
    end
  end

  assign full = (n_q >= NBits'(CAPACITY));

  always_comb begin
    case (op_q)
      cmst_pkg::OpCountLess:  cnt_hit = (rd_val_q < v_q);
      cmst_pkg::OpCountGreat: cnt_hit = (rd_val_q > v_q);
      cmst_pkg::OpCountEqual: cnt_hit = (rd_val_q == v_q);
      default:                cnt_hit = 1'b0;
    endcase
  end

  // The total is kept exact and wide; a saturating sum of counts is simply
  // the exact sum clipped, so each change only adds and removes its own part.
  always_comb begin
    ins_sum   = cmst_pkg::sat_add(kc_q, DB'(amt_q));
    merge_sum = cmst_pkg::sat_add(k2c_q, kc_q);
    sum_add   = '0;
    sum_sub   = '0;
    case (op_q)
      cmst_pkg::OpInsert: begin
        if (amt_q != '0 && hit_q) begin
          sum_add = SumBits'(ins_sum);
          sum_sub = SumBits'(kc_q);
        end else if (amt_q != '0 && !full) begin
          sum_add = SumBits'(amt_q);
        end
      end
      cmst_pkg::OpEraseOne: begin
        if (hit_q) sum_sub = (kc_q > DB'(1)) ? SumBits'(1) : SumBits'(kc_q);
      end
      cmst_pkg::OpEraseAll: begin
        if (hit_q) sum_sub = SumBits'(kc_q);
      end
      cmst_pkg::OpReplace: begin
        if (hit_q && hit2_q && k2_q != k_q) begin
          sum_add = SumBits'(merge_sum);
          sum_sub = SumBits'(k2c_q) + SumBits'(kc_q);
        end
      end
      default: ;
    endcase
    sum_next = sum_q + sum_add - sum_sub;
  end

  wire [VALUE_BITS-1:0] in_v  = VALUE_BITS'(value_i[VB-1:0]);
  wire [VALUE_BITS-1:0] in_nv = VALUE_BITS'(new_value_i[VB-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      n_q        <= '0;
      sum_q      <= '0;
      done_q     <= 1'b0;
      op_q       <= '0;
      v_q        <= '0;
      nv_q       <= '0;
      amt_q      <= '0;
      pos_q      <= '0;
      i_q        <= '0;
      j_q        <= '0;
      vld_q      <= 1'b0;
      hit_q      <= 1'b0;
      hit2_q     <= 1'b0;
      uniq_q     <= 1'b0;
      k_q        <= '0;
      k2_q       <= '0;
      kc_q       <= '0;
      k2c_q      <= '0;
      gv_q       <= '0;
      gc_q       <= '0;
      lf_v_q     <= '0;
      lf_c_q     <= '0;
      lo_v_q     <= '0;
      lo_c_q     <= '0;
      nx_v_q     <= '0;
      nx_c_q     <= '0;
      acc_q      <= '0;
      wa_q       <= '0;
      wv_q       <= '0;
      wc_q       <= '0;
      shift_up_q <= 1'b0;
      pend_dn_q  <= 1'b0;
      grow_q     <= 1'b0;
      shrink_q   <= 1'b0;
      st_q       <= cmst_pkg::StDone;
      cnt_q      <= '0;
      vo_q       <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (start_i) begin
            op_q      <= operation_i;
            v_q       <= in_v;
            nv_q      <= in_nv;
            amt_q     <= insert_amount_i;
            pos_q     <= position_i;
            hit_q     <= 1'b0;
            hit2_q    <= 1'b0;
            uniq_q    <= 1'b0;
            acc_q     <= '0;
            gv_q      <= '0;
            gc_q      <= '0;
            pend_dn_q <= 1'b0;
            grow_q    <= 1'b0;
            shrink_q  <= 1'b0;
            st_q      <= cmst_pkg::StDone;
            cnt_q     <= '0;
            vo_q      <= '0;
            i_q       <= '0;
            j_q       <= '0;
            vld_q     <= 1'b0;
            state_q   <= SScan;
          end
        end
        SScan: begin
          vld_q <= (i_q < n_q);
          j_q   <= i_q;
          if (i_q < n_q) i_q <= i_q + 1'b1;
          if (vld_q) begin
            if (rd_val_q == v_q) begin
              hit_q <= 1'b1;
              k_q   <= j_q[IdxBits-1:0];
              kc_q  <= rd_cnt_q;
            end
            if (rd_val_q == nv_q) begin
              hit2_q <= 1'b1;
              k2_q   <= j_q[IdxBits-1:0];
              k2c_q  <= rd_cnt_q;
            end
            if (CmpBits'(j_q) == CmpBits'(pos_q)) begin
              gv_q <= rd_val_q;
              gc_q <= rd_cnt_q;
            end
            if (cnt_hit) acc_q <= cmst_pkg::sat_add(acc_q, rd_cnt_q);
            // Least frequent: a later equal count spoils the answer until a
            // strictly smaller one turns up.
            if (j_q == '0 || rd_cnt_q < lf_c_q) begin
              lf_v_q <= rd_val_q;
              lf_c_q <= rd_cnt_q;
              uniq_q <= 1'b1;
            end else if (rd_cnt_q == lf_c_q) begin
              uniq_q <= 1'b0;
            end
            if (j_q == '0 || rd_val_q < lo_v_q) begin
              lo_v_q <= rd_val_q;
              lo_c_q <= rd_cnt_q;
              if (j_q != '0) begin
                nx_v_q <= lo_v_q;
                nx_c_q <= lo_c_q;
              end
            end else if (j_q == NBits'(1) || rd_val_q < nx_v_q) begin
              nx_v_q <= rd_val_q;
              nx_c_q <= rd_cnt_q;
            end
          end
          if (!vld_q && i_q >= n_q) state_q <= SDecide;
        end
        SDecide: begin
          sum_q   <= sum_next;
          state_q <= SReply;
          case (op_q)
            cmst_pkg::OpInsert: begin
              if (amt_q == '0) begin
                st_q <= cmst_pkg::StBad;
              end else if (hit_q) begin
                cnt_q   <= ins_sum;
                wa_q    <= k_q;
                wv_q    <= v_q;
                wc_q    <= ins_sum;
                state_q <= SWrEntry;
              end else if (full) begin
                st_q <= cmst_pkg::StFull;
              end else begin
                cnt_q      <= DB'(amt_q);
                wa_q       <= '0;
                wv_q       <= v_q;
                wc_q       <= DB'(amt_q);
                grow_q     <= 1'b1;
                shift_up_q <= 1'b1;
                // Move the entries up from the top down, then write entry 0.
                if (n_q != '0) begin
                  i_q     <= n_q - 1'b1;
                  state_q <= SRead;
                end else begin
                  state_q <= SWrEntry;
                end
              end
            end
            cmst_pkg::OpEraseOne, cmst_pkg::OpEraseAll: begin
              if (!hit_q) begin
                st_q <= cmst_pkg::StMiss;
              end else if (op_q == cmst_pkg::OpEraseOne && kc_q > DB'(1)) begin
                cnt_q   <= DB'(1);
                wa_q    <= k_q;
                wv_q    <= v_q;
                wc_q    <= kc_q - DB'(1);
                state_q <= SWrEntry;
              end else begin
                cnt_q      <= kc_q;
                shrink_q   <= 1'b1;
                shift_up_q <= 1'b0;
                i_q        <= NBits'(k_q) + NBits'(1);
                if (NBits'(k_q) + NBits'(1) < n_q) state_q <= SRead;
              end
            end
            cmst_pkg::OpCount: begin
              if (!hit_q) st_q <= cmst_pkg::StMiss;
              else cnt_q <= kc_q;
            end
            cmst_pkg::OpGet: begin
              if (CmpBits'(pos_q) >= CmpBits'(n_q)) begin
                st_q <= cmst_pkg::StMiss;
              end else begin
                vo_q  <= DB'(gv_q);
                cnt_q <= gc_q;
              end
            end
            cmst_pkg::OpReplace: begin
              if (!hit_q) begin
                st_q <= cmst_pkg::StMiss;
              end else if (!hit2_q) begin
                cnt_q   <= kc_q;
                wa_q    <= k_q;
                wv_q    <= nv_q;
                wc_q    <= kc_q;
                state_q <= SWrEntry;
              end else if (k2_q == k_q) begin
                cnt_q <= kc_q;
              end else begin
                // Merge into the new value's entry, then close the old one.
                cnt_q      <= merge_sum;
                wa_q       <= k2_q;
                wv_q       <= nv_q;
                wc_q       <= merge_sum;
                pend_dn_q  <= 1'b1;
                shrink_q   <= 1'b1;
                shift_up_q <= 1'b0;
                state_q    <= SWrEntry;
              end
            end
            cmst_pkg::OpCountLess, cmst_pkg::OpCountGreat, cmst_pkg::OpCountEqual: begin
              cnt_q <= acc_q;
            end
            cmst_pkg::OpLeastFreq: begin
              if (n_q == '0 || !uniq_q) begin
                st_q <= cmst_pkg::StMiss;
              end else begin
                vo_q  <= DB'(lf_v_q);
                cnt_q <= lf_c_q;
              end
            end
            cmst_pkg::OpSmallest: begin
              if (n_q == '0) begin
                st_q <= cmst_pkg::StMiss;
              end else begin
                vo_q  <= DB'(lo_v_q);
                cnt_q <= lo_c_q;
              end
            end
            cmst_pkg::OpSecondSm: begin
              if (n_q < NBits'(2)) begin
                st_q <= cmst_pkg::StMiss;
              end else begin
                vo_q  <= DB'(nx_v_q);
                cnt_q <= nx_c_q;
              end
            end
            default: st_q <= cmst_pkg::StBad;
          endcase
        end
        SWrEntry: begin
          if (pend_dn_q) begin
            i_q <= NBits'(k_q) + NBits'(1);
            if (NBits'(k_q) + NBits'(1) < n_q) state_q <= SRead;
            else state_q <= SReply;
          end else begin
            state_q <= SReply;
          end
        end
        SRead: begin
          state_q <= SWrite;
        end
        SWrite: begin
          if (shift_up_q) begin
            if (i_q == '0) begin
              state_q <= SWrEntry;
            end else begin
              i_q     <= i_q - 1'b1;
              state_q <= SRead;
            end
          end else begin
            if (i_q + NBits'(1) < n_q) begin
              i_q     <= i_q + 1'b1;
              state_q <= SRead;
            end else begin
              state_q <= SReply;
            end
          end
        end
        SReply: begin
          n_q     <= n_q + NBits'(grow_q) - NBits'(shrink_q);
          done_q  <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign busy_o             = (state_q != SIdle);
  assign done_o             = done_q;
  assign status_o           = st_q;
  assign value_out_o        = vo_q;
  assign count_out_o        = cnt_q;
  assign distinct_total_o   = cmst_pkg::TotalBits'(n_q);
  assign occurrence_total_o = (|sum_q[SumBits-1:DB]) ? '1 : sum_q[DB-1:0];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NBits'(CAPACITY)) else $error("entry count beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("command not taken");

endmodule
